>>> rtl/core/light_bar_pair_matcher_macros.svh
// Assertion macros for the light bar pair matcher controller
`ifndef LIGHT_BAR_PAIR_MATCHER_MACROS_SVH
`define LIGHT_BAR_PAIR_MATCHER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LBPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbpm assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define LBPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbpm assertion failed");

`endif

>>> rtl/core/lbpm_pkg.sv
// Shared constants and controller/datapath interface types for the pair matcher
package lbpm_pkg;

    localparam int FRAC_BITS = 4;
    localparam int SCALE     = 1 << FRAC_BITS;
    localparam int PIX_W     = 16 - FRAC_BITS;   // integer pixel part of a centre
    localparam int WPIX_W    = 12 - FRAC_BITS;   // integer pixel part of a width

    // angle thresholds, degrees in fixed point
    localparam logic signed [15:0] ANG_180  = 16'(180 * SCALE);
    localparam logic signed [15:0] ANG_165  = 16'(165 * SCALE);
    localparam logic signed [15:0] ANG_15   = 16'(15 * SCALE);
    localparam logic signed [15:0] ANG_M1   = -16'(SCALE);
    localparam logic signed [15:0] ANG_140  = 16'(140 * SCALE);
    localparam logic signed [15:0] ANG_SMAX = 16'sd4095;
    localparam logic signed [15:0] ANG_SMIN = -16'sd4096;

    // dy^4 overflows the width range once dy reaches this
    localparam logic [15:0] DY_SAT_LIM = 16'(1 << (10 + FRAC_BITS / 2));

    // square root: radicand, root and step count
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam logic [19:0] WIDTH_MAX   = 20'hFFFFF;
    localparam logic [11:0] LIMIT_RESET = 12'd160;

    typedef struct packed {
        logic load;   // capture item and previous bar
        logic test;   // evaluate pair tests, squares
        logic sum;    // form radicand, start root
        logic root;   // one square-root step
        logic emit;   // write output register
    } t_cmd;

    typedef struct packed {
        logic pass;   // pair passed every test
    } t_sts;

endpackage

>>> rtl/core/light_bar_pair_matcher.sv
// A bar that gives no target passes through idle (load), test and check; a bar that
// gives a target also takes the radicand sum, 25 steps of the bit-serial root unit and
// the output write. The next bar is held off until the previous bar is finished.
// A waiting target does not block the next bar until that bar's own output write.
// Reset (synchronous, active low) clears the previous bar, the output valid and
// sets the angle pair limit to 160 (10 degrees).
module light_bar_pair_matcher
    import lbpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_first_of_frame,
    input  logic [15:0]        i_center_x,
    input  logic [15:0]        i_center_y,
    input  logic [11:0]        i_bar_width,
    input  logic [11:0]        i_bar_height,
    input  logic signed [12:0] i_bar_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_target_x,
    output logic [15:0]        o_target_y,
    output logic [19:0]        o_target_width,
    output logic [11:0]        o_target_height,
    output logic signed [12:0] o_target_angle
);

    t_cmd cmd;
    t_sts sts;

    lbpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lbpm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_first_of_frame (i_first_of_frame),
        .i_center_x       (i_center_x),
        .i_center_y       (i_center_y),
        .i_bar_width      (i_bar_width),
        .i_bar_height     (i_bar_height),
        .i_bar_angle      (i_bar_angle),
        .o_target_x       (o_target_x),
        .o_target_y       (o_target_y),
        .o_target_width   (o_target_width),
        .o_target_height  (o_target_height),
        .o_target_angle   (o_target_angle)
    );

endmodule

>>> rtl/core/lbpm_dp.sv
// Datapath: previous bar, pair tests, squares and bit-serial square root
module lbpm_dp
    import lbpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_first_of_frame,
    input  logic [15:0]        i_center_x,
    input  logic [15:0]        i_center_y,
    input  logic [11:0]        i_bar_width,
    input  logic [11:0]        i_bar_height,
    input  logic signed [12:0] i_bar_angle,
    output logic [15:0]        o_target_x,
    output logic [15:0]        o_target_y,
    output logic [19:0]        o_target_width,
    output logic [11:0]        o_target_height,
    output logic signed [12:0] o_target_angle
);

    logic [11:0]        r_limit;
    logic               r_prev_valid;
    logic [15:0]        r_prev_x, r_prev_y;
    logic [11:0]        r_prev_w, r_prev_h;
    logic signed [12:0] r_prev_a;

    logic               r_pair;
    logic [15:0]        r_px, r_py, r_nx, r_ny;
    logic [11:0]        r_pw, r_ph, r_nw, r_nh;
    logic signed [12:0] r_pa, r_na;

    logic               r_pass, r_sat;
    logic [31:0]        r_dx2, r_dy2;
    logic [47:0]        r_d4;
    logic [15:0]        r_mx, r_my;
    logic [11:0]        r_maxh;
    logic signed [12:0] r_ang;

    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W+1:0]  r_rem;
    logic [ROOT_W-1:0]  r_root;

    // config register, written any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // previous bar: every item becomes the previous one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_w     <= '0;
            r_prev_h     <= '0;
            r_prev_a     <= '0;
        end else if (i_cmd.load) begin
            r_prev_valid <= 1'b1;
            r_prev_x     <= i_center_x;
            r_prev_y     <= i_center_y;
            r_prev_w     <= i_bar_width;
            r_prev_h     <= i_bar_height;
            r_prev_a     <= i_bar_angle;
        end
    end

    // operand capture; a pair needs a previous bar strictly to the left
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pair <= !i_first_of_frame && r_prev_valid && (r_prev_x < i_center_x);
            r_px   <= r_prev_x;
            r_py   <= r_prev_y;
            r_pw   <= r_prev_w;
            r_ph   <= r_prev_h;
            r_pa   <= r_prev_a;
            r_nx   <= i_center_x;
            r_ny   <= i_center_y;
            r_nw   <= i_bar_width;
            r_nh   <= i_bar_height;
            r_na   <= i_bar_angle;
        end
    end

    // pair tests
    logic [11:0]        minw, minh, maxh, hdiff;
    logic [15:0]        dx, dy;
    logic [PIX_W-1:0]   dpix;
    logic [WPIX_W-1:0]  tpix;
    logic               sp_ok, ang_ok, y_ok;
    logic signed [15:0] ap, an, lim, adiff, aabs, wrap_pn, wrap_np, v, half, ang;
    logic               hb_p, lb_p, hb_n, lb_n;

    always_comb begin
        minw  = (r_pw < r_nw) ? r_pw : r_nw;
        minh  = (r_ph < r_nh) ? r_ph : r_nh;
        maxh  = (r_ph > r_nh) ? r_ph : r_nh;
        hdiff = (r_ph > r_nh) ? (r_ph - r_nh) : (r_nh - r_ph);
        dx    = r_nx - r_px;
        dy    = (r_ny > r_py) ? (r_ny - r_py) : (r_py - r_ny);
        dpix  = r_nx[15:FRAC_BITS] - r_px[15:FRAC_BITS];
        tpix  = minw[11:FRAC_BITS];
        sp_ok = (24'(dpix) * 24'd10 > 24'(tpix) * 24'd8)
             && (24'(dpix) < 24'(tpix) * 24'd50);
        y_ok  = (24'(dy) * 24'd10 < 24'(minh) * 24'd7)
             && (24'(hdiff) * 24'd10 < 24'(minh) * 24'd4);

        ap    = 16'(r_pa);
        an    = 16'(r_na);
        lim   = signed'({4'b0, r_limit});
        hb_p  = (ap < ANG_180) && (ap > ANG_165);
        lb_p  = (ap < ANG_15) && (ap > ANG_M1);
        hb_n  = (an < ANG_180) && (an > ANG_165);
        lb_n  = (an < ANG_15) && (an > ANG_M1);
        adiff = ap - an;
        aabs  = (adiff < 0) ? -adiff : adiff;
        wrap_pn = ANG_180 - ap + an;
        wrap_np = ANG_180 - an + ap;
        if (hb_p && lb_n) begin
            ang_ok = wrap_pn < lim;
        end else if (hb_n && lb_p) begin
            ang_ok = wrap_np < lim;
        end else begin
            ang_ok = aabs < lim;
        end

        // combined angle: folded across 180 when the bars differ widely
        v    = ANG_180 - ap - an;
        half = v >>> 1;
        if (aabs > ANG_140) begin
            if (half > ANG_SMAX) begin
                ang = ANG_SMAX;
            end else if (half < ANG_SMIN) begin
                ang = ANG_SMIN;
            end else begin
                ang = half;
            end
        end else begin
            ang = (ap < an) ? ap : an;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_pass <= r_pair && sp_ok && ang_ok && y_ok;
            r_sat  <= dy >= DY_SAT_LIM;
            r_dx2  <= 32'(dx) * 32'(dx);
            r_dy2  <= 32'(dy) * 32'(dy);
            r_mx   <= 16'((17'(r_px) + 17'(r_nx)) >> 1);
            r_my   <= 16'((17'(r_py) + 17'(r_ny)) >> 1);
            r_maxh <= maxh;
            r_ang  <= 13'(ang);
        end
    end

    // fourth power of dy, registered in the cycle after the squares
    always_ff @(posedge i_clk) begin
        r_d4 <= 48'(r_dy2[23:0]) * 48'(r_dy2[23:0]);
    end

    // square root, one result bit per step
    logic [ROOT_W+1:0] rem_sh, trial;
    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_rad  <= (RAD_W'(33'(r_dx2) + 33'(r_dy2)) << (2 * FRAC_BITS)) + RAD_W'(r_d4);
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // output register
    logic [ROOT_W-FRAC_BITS-1:0] wroot;
    assign wroot = r_root[ROOT_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_target_x      <= r_mx;
            o_target_y      <= r_my;
            o_target_width  <= (r_sat || wroot > (ROOT_W-FRAC_BITS)'(WIDTH_MAX))
                             ? WIDTH_MAX : 20'(wroot);
            o_target_height <= r_maxh;
            o_target_angle  <= r_ang;
        end
    end

    assign o_sts.pass = r_pass;

endmodule

>>> rtl/core/lbpm_ctrl.sv
// Controller: sequences tests, squares and square-root steps; owns the handshakes
module lbpm_ctrl
    import lbpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

`include "light_bar_pair_matcher_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_CHECK,
        S_SUM,
        S_ROOT,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept, emit_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign emit_ok     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.pass ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `LBPM_ASSERT_IMP(a_emit_no_overwrite, o_cmd.emit, !(r_out_valid && i_out_stall))
    `LBPM_ASSERT_NXT(a_accept_to_test, accept, r_state == S_TEST)
    `LBPM_ASSERT_IMP(a_root_count_range, r_state == S_ROOT, r_cnt < CNT_W'(SQRT_STEPS))
    `LBPM_ASSERT_NXT(a_emit_sets_valid, o_cmd.emit, r_out_valid)

endmodule

>>> test/tb.sv
// Self-checking testbench for the light bar pair matcher: pairing prediction and target checks
module tb;
    import lbpm_pkg::*;

    // expected target of one pair
    typedef struct packed {
        logic [15:0]        tx;
        logic [15:0]        ty;
        logic [19:0]        tw;
        logic [11:0]        th;
        logic signed [12:0] ta;
    } t_target;

    // pairing predictor with its own copy of the previous bar and the angle limit
    class target_board;
        t_target            pending[$];
        int                 mismatches;
        logic [11:0]        ang_limit;
        bit                 have_prev;
        logic [15:0]        px, py;
        logic [11:0]        pw, ph;
        int                 pa;

        function void clear();
            ang_limit = LIMIT_RESET;
            have_prev = 0;
            px = 0; py = 0; pw = 0; ph = 0; pa = 0;
            mismatches = 0;
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [19:0] span_width(longint unsigned dx, longint unsigned dy);
            longint unsigned a, b, cap, r;
            a = (dx * dx + dy * dy) << (2 * FRAC_BITS);
            b = (dy * dy) * (dy * dy);
            cap = 64'd1 << (40 + 2 * FRAC_BITS);
            if (a >= cap || b >= cap) return WIDTH_MAX;
            r = root64(a + b) >> FRAC_BITS;
            return (r > 64'hFFFFF) ? WIDTH_MAX : r[19:0];
        endfunction

        function bit angles_agree(int ap, int an);
            int lim, d;
            lim = ang_limit;
            if (ap < 180*SCALE && ap > 165*SCALE && an < 15*SCALE && an > -SCALE)
                return 180*SCALE - ap + an < lim;
            if (an < 180*SCALE && an > 165*SCALE && ap < 15*SCALE && ap > -SCALE)
                return 180*SCALE - an + ap < lim;
            d = ap - an;
            if (d < 0) d = -d;
            return d < lim;
        endfunction

        // note an accepted bar, queue the target it yields
        function void note_bar(bit first, logic [15:0] nx, logic [15:0] ny,
                               logic [11:0] nw, logic [11:0] nh, logic signed [12:0] nang);
            longint t, d, minh, dy, dh, diff, ang;
            bit ok;
            t_target e;
            if (!first && have_prev && px < nx) begin
                t = ((pw < nw) ? pw : nw) >> FRAC_BITS;
                d = (nx >> FRAC_BITS) - (px >> FRAC_BITS);
                minh = (ph < nh) ? ph : nh;
                dy = (ny > py) ? ny - py : py - ny;
                dh = (nh > ph) ? nh - ph : ph - nh;
                ok = (10*d > 8*t) && (d < 50*t) && angles_agree(pa, int'(nang))
                     && (10*dy < 7*minh) && (10*dh < 4*minh);
                if (ok) begin
                    diff = pa - nang;
                    if (diff < 0) diff = -diff;
                    if (diff > 140*SCALE) ang = (180*SCALE - pa - nang) >>> 1;
                    else ang = (pa < nang) ? pa : nang;
                    if (ang > 4095) ang = 4095;
                    if (ang < -4096) ang = -4096;
                    // midpoints keep the carry of the sum
                    e.tx = 16'((17'(px) + 17'(nx)) >> 1);
                    e.ty = 16'((17'(py) + 17'(ny)) >> 1);
                    e.tw = span_width(nx - px, dy);
                    e.th = (ph > nh) ? ph : nh;
                    e.ta = 13'(ang);
                    pending.insert(pending.size(), e);
                end
            end
            have_prev = 1;
            px = nx; py = ny; pw = nw; ph = nh; pa = nang;
        endfunction

        function void check_target(t_target got);
            t_target e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected target %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) $display("target mismatch exp %p got %p", e, got);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [11:0]        i_cfg_data = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic               i_first_of_frame = 0;
    logic [15:0]        i_center_x = 0, i_center_y = 0;
    logic [11:0]        i_bar_width = 0, i_bar_height = 0;
    logic signed [12:0] i_bar_angle = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [15:0]        o_target_x, o_target_y;
    logic [19:0]        o_target_width;
    logic [11:0]        o_target_height;
    logic signed [12:0] o_target_angle;

    target_board board;
    int  send_idle_pct, recv_stall_pct;
    int  cycles;

    always #4 i_clk = ~i_clk;

    light_bar_pair_matcher u_dut (.*);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("light_bar_pair_matcher verification failed");
            $finish;
        end
    end

    // receiver: random stall, check accepted targets
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_target({o_target_x, o_target_y, o_target_width,
                                o_target_height, o_target_angle});
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_bar(bit f, logic [15:0] x, logic [15:0] y, logic [11:0] w,
                            logic [11:0] h, logic signed [12:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_first_of_frame <= f;
        i_center_x <= x; i_center_y <= y;
        i_bar_width <= w; i_bar_height <= h; i_bar_angle <= a;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_bar(f, x, y, w, h, a);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [11:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.ang_limit = v;
    endtask

    function automatic logic signed [12:0] rand_angle();
        case ($urandom_range(3))
            0: return 13'($urandom_range(2895) - 16);
            1: return 13'($urandom_range(8191));
            2: return 13'($urandom_range(15*SCALE + 15) - 16);
            default: return 13'(165*SCALE + $urandom_range(15*SCALE + 15));
        endcase
    endfunction

    // a neighbour of the previous bar that mostly passes the tests
    task automatic send_partner();
        logic [15:0] x, y;
        logic [11:0] w, h;
        logic signed [12:0] a;
        w = board.pw + 12'($urandom_range(40)) - 12'd20;
        h = board.ph + 12'($urandom_range(16)) - 12'd8;
        x = board.px + 16'($urandom_range(60*SCALE, 16*((board.pw >> 4) + 1)));
        y = board.py + 16'($urandom_range(32)) - 16'd16;
        a = 13'(board.pa + int'($urandom_range(200)) - 100);
        if ($urandom_range(9) == 0) a = rand_angle();
        send_bar(0, x, y, w, h, a);
    endtask

    initial begin
        int phase, n;
        board = new();
        board.clear();
        cycles = 0;
        send_idle_pct = 15;
        recv_stall_pct = 69;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: no previous bar, extremes, wrap, reversed order, saturation
        send_bar(0, 16'd1600, 16'd1600, 12'd320, 12'd800, 13'sd0);
        send_bar(0, 16'd3200, 16'd1610, 12'd320, 12'd810, 13'sd16);
        send_bar(0, 16'd3200, 16'd1610, 12'd320, 12'd810, 13'sd16);
        send_bar(0, 16'd100, 16'd1610, 12'd320, 12'd810, 13'sd16);
        send_bar(0, 16'd1700, 16'd1610, 12'd0, 12'd810, 13'sd16);
        send_bar(1, 16'd0, 16'd0, 12'd4095, 12'd4095, 13'sd2870);
        send_bar(0, 16'd1600, 16'd300, 12'd4095, 12'd4095, -13'sd10);
        send_bar(0, 16'd3200, 16'd400, 12'd4095, 12'd4000, 13'sd2875);
        send_bar(0, 16'd4800, 16'd10, 12'd4095, 12'd4000, 13'sd100);
        send_bar(1, 16'd0, 16'd65535, 12'd4095, 12'd4095, -13'sd16);
        send_bar(0, 16'd65535, 16'd0, 12'd4095, 12'd4095, -13'sd4096);
        send_bar(1, 16'd0, 16'd0, 12'd4095, 12'd4095, 13'sd4095);
        send_bar(0, 16'd65535, 16'd65535, 12'd4095, 12'd4095, -13'sd4096);
        write_limit(12'd2880);
        send_bar(1, 16'd1000, 16'd1000, 12'd4095, 12'd4095, 13'sd4095);
        send_bar(0, 16'd7000, 16'd5000, 12'd4095, 12'd4095, -13'sd4096);
        send_bar(0, 16'd9000, 16'd5000, 12'd4095, 12'd4095, 13'sd2879);
        send_bar(0, 16'd20000, 16'd5100, 12'd4095, 12'd4095, -13'sd16);
        write_limit(12'd4095);
        send_bar(0, 16'd30000, 16'd5100, 12'd4095, 12'd4095, 13'sd4095);
        write_limit(12'd0);
        send_bar(0, 16'd40000, 16'd5100, 12'd4095, 12'd4095, 13'sd4095);

        // random: three idling phases with varied limits
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
            recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
            write_limit((phase == 0) ? 12'd160 : (phase == 1) ? 12'($urandom_range(4095))
                                                               : 12'd2880);
            for (n = 0; n < 150; n++) begin
                if ($urandom_range(9) < 7 && board.have_prev) begin
                    send_partner();
                end else begin
                    send_bar($urandom_range(3) == 0, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 12'($urandom_range(4095)),
                             12'($urandom_range(4095)), rand_angle());
                end
                if (n == 75) drain();
            end
        end

        drain();
        if (board.mismatches == 0)
            $display("light_bar_pair_matcher verification clean");
        else
            $display("light_bar_pair_matcher verification failed");
        $finish;
    end
endmodule

>>> light_bar_pair_matcher.f
+incdir+rtl/core
rtl/core/lbpm_pkg.sv
rtl/core/lbpm_dp.sv
rtl/core/lbpm_ctrl.sv
rtl/core/light_bar_pair_matcher.sv
test/tb.sv
